### sv/btpc_pkg.sv
`timescale 1ns / 1ps

package btpc_pkg;

  // default fraction bits of the two results
  localparam int TEMP_FRAC_DEF  = 16;
  localparam int PRESS_FRAC_DEF = 6;

  // pipeline depth, one valid bit per stage
  localparam int NSTAGE = 9;

  // accumulator width for the pressure sums, holds every term over the
  // whole fraction range
  localparam int SUM_W = 58;

  // configuration port
  localparam int IDX_W  = 8;
  localparam int DATA_W = 48;

  localparam logic [IDX_W-1:0] REG_TEMP       = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PRESS_LOW  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_PRESS_MID  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_PRESS_HIGH = IDX_W'(3);

  // unpacked calibration words
  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coeff_t;

endpackage

### sv/btpc_datapath.sv
`timescale 1ns / 1ps

module btpc_datapath import btpc_pkg::*; #(
  parameter int TEMP_FRAC_BITS  = TEMP_FRAC_DEF,
  parameter int PRESS_FRAC_BITS = PRESS_FRAC_DEF
) (
  input  logic               clk,
  input  logic [NSTAGE-1:0]  ld,
  input  coeff_t             c,
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  output logic signed [23:0] temperature_q16,
  output logic [22:0]        pressure_q6,
  output logic               out_of_range
);

  localparam int F    = TEMP_FRAC_BITS;
  localparam int G    = PRESS_FRAC_BITS;
  localparam int U2W  = 48 - F;
  localparam int U3W  = 72 - 2 * F;
  localparam int QW   = ((16 + F > 31) ? 16 + F : 31) + 1;
  localparam int D2W  = 16 + F;
  localparam int A6W  = 36;
  localparam int CP2W = 45 - F;
  localparam int C3W  = U2W + 8 - F;
  localparam int WW   = QW + 1;
  localparam int D1W  = QW + 2;
  localparam int A8W  = U3W - 7;
  localparam int C4W  = U3W + 3 - F;
  localparam int BW   = 33 + F;

  localparam logic signed [59:0]      TQ_MAX = 60'sd8388607;
  localparam logic signed [59:0]      TQ_MIN = -60'sd8388608;
  localparam logic signed [SUM_W-1:0] C_LIM  = SUM_W'(64'sd274877906944);
  localparam logic signed [SUM_W-1:0] P_MAX  = SUM_W'(64'sd8388607);

  // ---------------- stage 1: temperature offset, raw pressure square
  logic signed [25:0] d_full;
  logic        [23:0] s1_rp;
  logic signed [24:0] s1_d;
  logic        [47:0] s1_x;

  assign d_full = $signed({2'b00, raw_temperature}) - $signed({2'b00, c.t1, 8'h00});

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_rp <= raw_pressure;
      s1_d  <= d_full[24:0];
      s1_x  <= raw_pressure * raw_pressure;
    end
  end

  // ---------------- stage 2: d*t2, d*d, cubic pressure term first product
  logic signed [41:0] m1_n;
  logic signed [49:0] dd_n;
  logic signed [56:0] xp_n;
  logic        [23:0] s2_rp;
  logic signed [41:0] s2_m1;
  logic signed [49:0] s2_dd;
  logic signed [32:0] s2_y;

  assign m1_n = s1_d * $signed({1'b0, c.t2});
  assign dd_n = s1_d * s1_d;
  assign xp_n = $signed({1'b0, s1_x}) * c.p11;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_rp <= s1_rp;
      s2_m1 <= m1_n;
      s2_dd <= dd_n;
      s2_y  <= xp_n[56:24];
    end
  end

  // ---------------- stage 3: linear temperature with saturation, d2 term
  logic signed [57:0] t3p_n;
  logic signed [59:0] t48_n;
  logic signed [59:0] tsh_n;
  logic signed [23:0] tq_n;
  logic               tsat_n;
  logic signed [57:0] yr_n;
  logic signed [57:0] yrs_n;
  logic        [23:0] s3_rp;
  logic signed [23:0] s3_tq;
  logic               s3_flag;
  logic signed [D2W-1:0] s3_d2;

  assign t3p_n = s2_dd * c.t3;
  assign t48_n = (60'(s2_m1) <<< 18) + 60'(t3p_n);
  assign tsh_n = t48_n >>> (48 - F);
  assign yr_n  = s2_y * $signed({1'b0, s2_rp});
  assign yrs_n = yr_n >>> (41 - F);

  always_comb begin
    tsat_n = 1'b1;
    if (tsh_n > TQ_MAX) begin
      tq_n = TQ_MAX[23:0];
    end else if (tsh_n < TQ_MIN) begin
      tq_n = TQ_MIN[23:0];
    end else begin
      tq_n   = tsh_n[23:0];
      tsat_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_rp   <= s2_rp;
      s3_tq   <= tq_n;
      s3_flag <= tsat_n;
      s3_d2   <= yrs_n[D2W-1:0];
    end
  end

  // ---------------- stage 4: tq squared, linear temperature terms, q
  logic signed [47:0] tt_n;
  logic signed [47:0] tts_n;
  logic signed [41:0] p6t_n;
  logic signed [41:0] a6s_n;
  logic signed [17:0] p2m_n;
  logic signed [44:0] p2t_n;
  logic signed [44:0] cp2s_n;
  logic signed [31:0] p10t_n;
  logic signed [QW-1:0] q_n;
  logic        [23:0] s4_rp;
  logic signed [23:0] s4_tq;
  logic               s4_flag;
  logic signed [D2W-1:0] s4_d2;
  logic signed [U2W-1:0] s4_u2;
  logic signed [A6W-1:0] s4_a6;
  logic signed [CP2W-1:0] s4_cp2;
  logic signed [QW-1:0] s4_q;

  assign tt_n   = s3_tq * s3_tq;
  assign tts_n  = tt_n >>> F;
  assign p6t_n  = $signed({1'b0, c.p6}) * s3_tq;
  assign a6s_n  = p6t_n >>> 6;
  assign p2m_n  = 18'(c.p2) - 18'sd16384;
  assign p2t_n  = p2m_n * s3_tq;
  assign cp2s_n = (p2t_n <<< 3) >>> F;
  assign p10t_n = c.p10 * s3_tq;
  assign q_n    = (QW'(c.p9) <<< F) + QW'(p10t_n);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_rp   <= s3_rp;
      s4_tq   <= s3_tq;
      s4_flag <= s3_flag;
      s4_d2   <= s3_d2;
      s4_u2   <= tts_n[U2W-1:0];
      s4_a6   <= a6s_n[A6W-1:0];
      s4_cp2  <= cp2s_n[CP2W-1:0];
      s4_q    <= q_n;
    end
  end

  // ---------------- stage 5: tq cubed, quadratic terms, first d1 product
  logic signed [U2W+23:0] u3p_n;
  logic signed [U2W+23:0] u3s_n;
  logic signed [U2W+7:0]  p7u_n;
  logic signed [U2W+7:0]  a7s_n;
  logic signed [U2W+7:0]  p3u_n;
  logic signed [U2W+7:0]  c3s_n;
  logic signed [QW+24:0]  rq_n;
  logic signed [QW+24:0]  rqs_n;
  logic        [23:0] s5_rp;
  logic               s5_flag;
  logic signed [D2W-1:0]  s5_d2;
  logic signed [A6W-1:0]  s5_a6;
  logic signed [CP2W-1:0] s5_cp2;
  logic signed [U3W-1:0]  s5_u3;
  logic signed [U2W-1:0]  s5_a7;
  logic signed [C3W-1:0]  s5_c3;
  logic signed [WW-1:0]   s5_w;

  assign u3p_n = s4_u2 * s4_tq;
  assign u3s_n = u3p_n >>> F;
  assign p7u_n = c.p7 * s4_u2;
  assign a7s_n = p7u_n >>> 8;
  assign p3u_n = c.p3 * s4_u2;
  assign c3s_n = p3u_n >>> F;
  assign rq_n  = $signed({1'b0, s4_rp}) * s4_q;
  assign rqs_n = rq_n >>> 24;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_rp   <= s4_rp;
      s5_flag <= s4_flag;
      s5_d2   <= s4_d2;
      s5_a6   <= s4_a6;
      s5_cp2  <= s4_cp2;
      s5_u3   <= u3s_n[U3W-1:0];
      s5_a7   <= a7s_n[U2W-1:0];
      s5_c3   <= c3s_n[C3W-1:0];
      s5_w    <= rqs_n[WW-1:0];
    end
  end

  // ---------------- stage 6: cubic terms, d1, partial sums of A and C
  logic signed [U3W+7:0]  p8u_n;
  logic signed [U3W+7:0]  a8s_n;
  logic signed [U3W+7:0]  p4u_n;
  logic signed [U3W+7:0]  c4s_n;
  logic signed [WW+24:0]  rw_n;
  logic signed [WW+24:0]  rws_n;
  logic signed [17:0]     p1m_n;
  logic signed [SUM_W-1:0] aa_n;
  logic signed [SUM_W-1:0] cc_n;
  logic        [23:0] s6_rp;
  logic               s6_flag;
  logic signed [D2W-1:0]  s6_d2;
  logic signed [A8W-1:0]  s6_a8;
  logic signed [C4W-1:0]  s6_c4;
  logic signed [D1W-1:0]  s6_d1;
  logic signed [SUM_W-1:0] s6_aa;
  logic signed [SUM_W-1:0] s6_cc;

  assign p8u_n = c.p8 * s5_u3;
  assign a8s_n = p8u_n >>> 15;
  assign p4u_n = c.p4 * s5_u3;
  assign c4s_n = p4u_n >>> (5 + F);
  assign rw_n  = $signed({1'b0, s5_rp}) * s5_w;
  assign rws_n = rw_n >>> 24;
  assign p1m_n = 18'(c.p1) - 18'sd16384;
  assign aa_n  = (SUM_W'($signed({1'b0, c.p5})) <<< (3 + F)) + SUM_W'(s5_a6)
               + SUM_W'(s5_a7);
  assign cc_n  = (SUM_W'(p1m_n) <<< 12) + SUM_W'(s5_cp2) + SUM_W'(s5_c3);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_rp   <= s5_rp;
      s6_flag <= s5_flag;
      s6_d2   <= s5_d2;
      s6_a8   <= a8s_n[A8W-1:0];
      s6_c4   <= c4s_n[C4W-1:0];
      s6_d1   <= rws_n[D1W-1:0];
      s6_aa   <= aa_n;
      s6_cc   <= cc_n;
    end
  end

  // ---------------- stage 7: finish A plus d1 and d2, clamp sensitivity
  logic signed [SUM_W-1:0] ad_n;
  logic signed [SUM_W-1:0] cs_n;
  logic signed [SUM_W-1:0] cl_n;
  logic               csat_n;
  logic        [23:0] s7_rp;
  logic               s7_flag;
  logic signed [SUM_W-1:0] s7_ad;
  logic signed [39:0] s7_c;

  assign ad_n = s6_aa + SUM_W'(s6_a8) + SUM_W'(s6_d1) + SUM_W'(s6_d2);
  assign cs_n = s6_cc + SUM_W'(s6_c4);

  always_comb begin
    csat_n = 1'b1;
    if (cs_n > C_LIM) begin
      cl_n = C_LIM;
    end else if (cs_n < -C_LIM) begin
      cl_n = -C_LIM;
    end else begin
      cl_n   = cs_n;
      csat_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s7_rp   <= s6_rp;
      s7_flag <= s6_flag | csat_n;
      s7_ad   <= ad_n;
      s7_c    <= cl_n[39:0];
    end
  end

  // ---------------- stage 8: raw pressure times sensitivity
  logic signed [64:0] rc_n;
  logic signed [64:0] rcs_n;
  logic               s8_flag;
  logic signed [SUM_W-1:0] s8_ad;
  logic signed [BW-1:0] s8_b;

  assign rc_n  = $signed({1'b0, s7_rp}) * s7_c;
  assign rcs_n = rc_n >>> (32 - F);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s8_flag <= s7_flag;
      s8_ad   <= s7_ad;
      s8_b    <= rcs_n[BW-1:0];
    end
  end

  // ---------------- stage 9: final sum, scale, saturate into output word
  logic signed [SUM_W-1:0] p_n;
  logic signed [SUM_W-1:0] ps_n;
  logic        [22:0] pq_n;
  logic               psat_n;

  assign p_n  = s8_ad + SUM_W'(s8_b);
  assign ps_n = p_n >>> (F - G);

  always_comb begin
    psat_n = 1'b1;
    if (ps_n > P_MAX) begin
      pq_n = P_MAX[22:0];
    end else if (ps_n < 0) begin
      pq_n = '0;
    end else begin
      pq_n   = ps_n[22:0];
      psat_n = 1'b0;
    end
  end

  // temperature rides along from stage 4 through a short delay line
  logic signed [23:0] tq_d5, tq_d6, tq_d7, tq_d8;

  always_ff @(posedge clk) begin
    if (ld[4]) tq_d5 <= s4_tq;
    if (ld[5]) tq_d6 <= tq_d5;
    if (ld[6]) tq_d7 <= tq_d6;
    if (ld[7]) tq_d8 <= tq_d7;
    if (ld[8]) begin
      temperature_q16 <= tq_d8;
      pressure_q6     <= pq_n;
      out_of_range    <= s8_flag | psat_n;
    end
  end

endmodule

### sv/baro_temp_press_compensation.sv
`timescale 1ns / 1ps

// Pressure and temperature compensation for a barometric sensor.
// Input channel: in_valid / in_stall carry one word, a raw pressure and a raw
// temperature conversion pair. Output channel: out_valid / out_stall carry one
// word: temperature in degrees C (Q16), pressure in pascal (Q6), and a flag
// set when either result or the pressure sensitivity was saturated.
// Calibration words are written through cfg_valid / cfg_ready, cfg_index
// selecting the register (0 temperature, 1..3 pressure low/mid/high); other
// indexes are ignored. cfg_ready is always high. Write only while idle.
// Nine register stages: the first loads at the accepting edge; the longest
// stage is one multiplier of at most 40 by 25 bits plus a shift.
// Throughput is one word per cycle while out_stall is low. A stall on the
// output holds the last stage; bubbles further up still close, and in_stall
// rises only once every stage holds a word. Reset (synchronous) empties the
// pipeline and clears all calibration words to zero.

module baro_temp_press_compensation import btpc_pkg::*; #(
  parameter int TEMP_FRAC_BITS  = TEMP_FRAC_DEF,
  parameter int PRESS_FRAC_BITS = PRESS_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] temperature_q16,
  output logic [22:0]        pressure_q6,
  output logic               out_of_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]  cfg_data
);

  logic [39:0]       temp_coeffs;
  logic [47:0]       press_coeffs_low;
  logic [47:0]       press_coeffs_mid;
  logic [31:0]       press_coeffs_high;
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] ld;
  coeff_t            c;

  assign cfg_ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_mid  <= '0;
      press_coeffs_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP:       temp_coeffs       <= cfg_data[39:0];
        REG_PRESS_LOW:  press_coeffs_low  <= cfg_data;
        REG_PRESS_MID:  press_coeffs_mid  <= cfg_data;
        REG_PRESS_HIGH: press_coeffs_high <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // unpack calibration words
  always_comb begin
    c.t1  = temp_coeffs[15:0];
    c.t2  = temp_coeffs[31:16];
    c.t3  = temp_coeffs[39:32];
    c.p1  = press_coeffs_low[15:0];
    c.p2  = press_coeffs_low[31:16];
    c.p3  = press_coeffs_low[39:32];
    c.p4  = press_coeffs_low[47:40];
    c.p5  = press_coeffs_mid[15:0];
    c.p6  = press_coeffs_mid[31:16];
    c.p7  = press_coeffs_mid[39:32];
    c.p8  = press_coeffs_mid[47:40];
    c.p9  = press_coeffs_high[15:0];
    c.p10 = press_coeffs_high[23:16];
    c.p11 = press_coeffs_high[31:24];
  end

  // stage load enables: a stage loads when empty or when the next one moves
  always_comb begin
    ld[NSTAGE-1] = !v[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = v[NSTAGE-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  btpc_datapath #(
    .TEMP_FRAC_BITS  (TEMP_FRAC_BITS),
    .PRESS_FRAC_BITS (PRESS_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .ld              (ld),
    .c               (c),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .temperature_q16 (temperature_q16),
    .pressure_q6     (pressure_q6),
    .out_of_range    (out_of_range)
  );

endmodule

### sv/btpc_checker.sv
`timescale 1ns / 1ps

module btpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] temperature_q16,
  input logic [22:0]        pressure_q6,
  input logic               out_of_range
);

  // a held word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // a held word keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(temperature_q16) && $stable(pressure_q6)
      && $stable(out_of_range))
    else $error("output word changed while stalled");

  // an empty output stage never pushes back on the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with output stage empty");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("word offered right after reset");

endmodule

bind baro_temp_press_compensation btpc_checker u_checker (.*);

### test/baro_checker.sv
`timescale 1ns / 1ps

module baro_checker import btpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] temperature_q16,
  input  logic [22:0]        pressure_q6,
  input  logic               out_of_range,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  localparam int F = TEMP_FRAC_DEF;
  localparam int G = PRESS_FRAC_DEF;
  localparam longint C_CLAMP = 64'sd1 <<< 38;
  localparam longint T_HI = 64'sd8388607;
  localparam longint T_LO = -64'sd8388608;
  localparam longint P_HI = 64'sd8388607;

  typedef struct packed {
    logic [23:0] tq;
    logic [22:0] pq;
    logic        flag;
  } comp_t;

  // local copy of the calibration registers
  logic [39:0] cal_temp;
  logic [47:0] cal_plow;
  logic [47:0] cal_pmid;
  logic [31:0] cal_phigh;

  comp_t comp_q[$];

  assign pending = comp_q.size();

  // fixed-point compensation of one raw pair
  function automatic comp_t compensate(logic [23:0] rp_in, logic [23:0] rt_in);
    longint rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint d, t48, tq, u2, u3, a, c, b, q, w, d1, x, y, d2, p, pq;
    logic flag;
    comp_t r;
    flag = 1'b0;
    rp = rp_in;
    rt = rt_in;
    t1 = cal_temp[15:0];
    t2 = cal_temp[31:16];
    t3 = $signed(cal_temp[39:32]);
    p1 = $signed(cal_plow[15:0]);
    p2 = $signed(cal_plow[31:16]);
    p3 = $signed(cal_plow[39:32]);
    p4 = $signed(cal_plow[47:40]);
    p5 = cal_pmid[15:0];
    p6 = cal_pmid[31:16];
    p7 = $signed(cal_pmid[39:32]);
    p8 = $signed(cal_pmid[47:40]);
    p9 = $signed(cal_phigh[15:0]);
    p10 = $signed(cal_phigh[23:16]);
    p11 = $signed(cal_phigh[31:24]);

    // temperature
    d = rt - t1 * 256;
    t48 = d * t2 * 262144 + d * d * t3;
    tq = t48 >>> (48 - F);
    if (tq > T_HI) begin
      tq = T_HI;
      flag = 1'b1;
    end
    if (tq < T_LO) begin
      tq = T_LO;
      flag = 1'b1;
    end

    // pressure offset and sensitivity
    u2 = (tq * tq) >>> F;
    u3 = (u2 * tq) >>> F;
    a = p5 * 8 * (64'sd1 <<< F) + ((p6 * tq) >>> 6) + ((p7 * u2) >>> 8)
        + ((p8 * u3) >>> 15);
    c = (p1 - 16384) * 4096 + (((p2 - 16384) * tq * 8) >>> F)
        + ((p3 * u2) >>> F) + ((p4 * u3) >>> (5 + F));
    if (c > C_CLAMP) begin
      c = C_CLAMP;
      flag = 1'b1;
    end
    if (c < -C_CLAMP) begin
      c = -C_CLAMP;
      flag = 1'b1;
    end
    b = (rp * c) >>> (32 - F);

    // square and cube terms of the raw pressure
    q = p9 * (64'sd1 <<< F) + p10 * tq;
    w = (rp * q) >>> 24;
    d1 = (rp * w) >>> 24;
    x = rp * rp;
    y = (x * p11) >>> 24;
    d2 = (y * rp) >>> (41 - F);

    p = a + b + d1 + d2;
    pq = p >>> (F - G);
    if (pq > P_HI) begin
      pq = P_HI;
      flag = 1'b1;
    end
    if (pq < 0) begin
      pq = 0;
      flag = 1'b1;
    end
    r.tq = tq[23:0];
    r.pq = pq[22:0];
    r.flag = flag;
    return r;
  endfunction

  // watch the channels, predict and compare
  always @(posedge clk) begin : watch
    comp_t e;
    if (rst) begin
      cal_temp <= '0;
      cal_plow <= '0;
      cal_pmid <= '0;
      cal_phigh <= '0;
      comp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEMP:       cal_temp <= cfg_data[39:0];
          REG_PRESS_LOW:  cal_plow <= cfg_data[47:0];
          REG_PRESS_MID:  cal_pmid <= cfg_data[47:0];
          REG_PRESS_HIGH: cal_phigh <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (comp_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: result word with nothing expected", $time);
        end else begin
          e = comp_q.pop_front();
          checked <= checked + 1;
          if (temperature_q16 !== e.tq || pressure_q6 !== e.pq || out_of_range !== e.flag) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected t=%h p=%h f=%b actual t=%h p=%h f=%b",
                     $time, e.tq, e.pq, e.flag, temperature_q16, pressure_q6,
                     out_of_range);
          end
        end
      end
      if (in_valid && !in_stall)
        comp_q.push_back(compensate(raw_pressure, raw_temperature));
    end
  end

  initial begin
    errors = 0;
    checked = 0;
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb import btpc_pkg::*; ();

  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(255);
  localparam logic [IDX_W-1:0] REG_NEXT   = IDX_W'(4);
  localparam int CYCLE_LIMIT = 2000000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [23:0]        raw_pressure;
  logic [23:0]        raw_temperature;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] temperature_q16;
  logic [22:0]        pressure_q6;
  logic               out_of_range;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]  cfg_data;

  int errors, pending, checked;
  int words_sent, cfg_writes, cycles, stall_left;
  bit quiet;
  logic [15:0] cur_t1;

  baro_temp_press_compensation i_dut (
    .clk, .rst, .in_valid, .in_stall, .raw_pressure, .raw_temperature,
    .out_valid, .out_stall, .temperature_q16, .pressure_q6, .out_of_range,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  baro_checker i_chk (
    .clk, .rst, .in_valid, .in_stall, .raw_pressure, .raw_temperature,
    .out_valid, .out_stall, .temperature_q16, .pressure_q6, .out_of_range,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending, .checked
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // random back-pressure on the result side
  always @(posedge clk) begin : sink
    int n;
    n = stall_left;
    if (rst)
      n = 0;
    else if (out_valid && !out_stall)
      n = quiet ? 0 : $urandom_range(0, 11);
    else if (n > 0)
      n = n - 1;
    stall_left <= n;
    out_stall <= (n > 0);
  end

  // one raw pair, valid stays high after acceptance
  task automatic send_word(logic [23:0] rp, logic [23:0] rt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_pressure <= rp;
    raw_temperature <= rt;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // wait until the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TEMP) cur_t1 = data[15:0];
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic cfg_all(logic [47:0] t, logic [47:0] pl, logic [47:0] pm, logic [47:0] ph);
    cfg_write(REG_TEMP, t);
    cfg_write(REG_PRESS_LOW, pl);
    cfg_write(REG_PRESS_MID, pm);
    cfg_write(REG_PRESS_HIGH, ph);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  // raw temperature mostly near the calibration point
  function automatic logic [23:0] pick_temp();
    if ($urandom_range(0, 9) < 8)
      return 24'({cur_t1, 8'h00} + $urandom_range(0, 16383) - 8192);
    return 24'($urandom);
  endfunction

  // plausible calibration set
  localparam logic [47:0] CAL_T  = {8'h00, 8'hF6, 16'd19000, 16'd27158};
  localparam logic [47:0] CAL_PL = {8'h06, 8'h1C, 16'hFF90, 16'hE700};
  localparam logic [47:0] CAL_PM = {8'hFF, 8'h0F, 16'd9100, 16'd28000};
  localparam logic [47:0] CAL_PH = {16'h0000, 8'hF6, 8'h0B, 16'h13B0};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    raw_pressure = '0;
    raw_temperature = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    stall_left = 0;
    cycles = 0;
    words_sent = 0;
    cfg_writes = 0;
    quiet = 1'b1;
    cur_t1 = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration, field extremes
    send_word(24'h000000, 24'h000000);
    send_word(24'hFFFFFF, 24'hFFFFFF);
    send_word(24'h000000, 24'hFFFFFF);
    send_word(24'hFFFFFF, 24'h000000);
    drain();

    // plausible calibration, temperature at and around the calibration point
    cfg_all(CAL_T, CAL_PL, CAL_PM, CAL_PH);
    quiet = 1'b0;
    send_word(24'h000000, {cur_t1, 8'h00});
    send_word(24'h6E0000, {cur_t1, 8'h00});
    send_word(24'hFFFFFF, {cur_t1, 8'h00});
    send_word(24'h6E0000, 24'({cur_t1, 8'h00} + 24'h8000));
    send_word(24'h6E0000, 24'({cur_t1, 8'h00} - 24'h8000));
    // wild temperature, pressure uses the clamped value
    send_word(24'h6E0000, 24'hFFFFFF);
    send_word(24'h6E0000, 24'h000000);
    drain();

    // all-ones calibration: sensitivity clamp and saturation
    cfg_all('1, '1, '1, '1);
    send_word(24'h000000, 24'hFFFFFF);
    send_word(24'hFFFFFF, 24'hFFFFFF);
    send_word(24'h800000, 24'h000000);
    drain();

    // most negative signed words, ignored register indexes
    cfg_all(48'hFF80_FFFF_0000, 48'h8080_8000_8000, 48'h8080_FFFF_FFFF,
            48'h0000_8080_8000);
    cfg_write(REG_NEXT, '1);
    cfg_write(REG_UNUSED, '0);
    send_word(24'hFFFFFF, 24'h000000);
    send_word(24'hFFFFFF, 24'h7FFFFF);
    send_word(24'h000001, 24'hFFFFFF);
    send_word(24'h123456, 24'h000100);
    drain();

    // random phases, each with its own calibration
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        cfg_all(CAL_T, CAL_PL, CAL_PM, CAL_PH);
      else
        cfg_all(rand48(), rand48(), rand48(), rand48());
      quiet = (ph == 2);
      for (int k = 0; k < 272; k++)
        send_word(24'($urandom), pick_temp());
      drain();
    end

    $display("%0d words sent over %0d calibration writes, %0d results checked",
             words_sent, cfg_writes, checked);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### baro_temp_press_compensation.f
sv/btpc_pkg.sv
sv/btpc_datapath.sv
sv/baro_temp_press_compensation.sv
sv/btpc_checker.sv
test/baro_checker.sv
test/tb.sv
